@@ rtl/b64se_pkg.sv @@
// shared types, constants and symbol lookup for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64se_pkg;

	// depth of the group queue between front and back
	localparam int GrpQDepth = 2;
	localparam int GrpQPtrW  = (GrpQDepth > 1) ? $clog2(GrpQDepth) : 1;
	localparam int GrpQCntW  = $clog2(GrpQDepth + 1);

	localparam logic [6:0] PadChar = 7'd61;

	// symbol count codes for one emitted group
	localparam logic [2:0] NsymOne   = 3'd2;
	localparam logic [2:0] NsymTwo   = 3'd3;
	localparam logic [2:0] NsymThree = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
	} out_item_t;

	// one classified group handed from front to back
	typedef struct packed {
		logic [23:0] bits;
		logic [2:0]  nsym;
		logic        fin;
	} grp_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] sym_char(input logic [5:0] idx);
		logic [6:0] ch;
		if (idx < 6'd26) begin
			ch = 7'd65 + {1'b0, idx};
		end else if (idx < 6'd52) begin
			ch = 7'd97 + {1'b0, idx} - 7'd26;
		end else if (idx < 6'd62) begin
			ch = 7'd48 + {1'b0, idx} - 7'd52;
		end else if (idx == 6'd62) begin
			ch = 7'd43;
		end else begin
			ch = 7'd47;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ rtl/b64se_front.sv @@
// front end: gathers input bytes and classifies complete or final groups
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64se_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire b64se_pkg::in_item_t item,
	output logic                    q_push,
	output b64se_pkg::grp_t         q_data,
	input  wire logic               q_full
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        emit;

	assign full   = q_full;
	assign accept = push && !q_full;
	// a third byte or a final byte closes a group
	assign emit   = cnt_q[1] || item.last_byte;
	assign q_push = accept && emit;

	always_comb begin
		q_data.fin = item.last_byte;
		priority if (cnt_q[1]) begin
			q_data.bits = {pend_q, item.data_byte};
			q_data.nsym = b64se_pkg::NsymThree;
		end else if (cnt_q[0]) begin
			q_data.bits = {pend_q[15:8], item.data_byte, 8'h00};
			q_data.nsym = b64se_pkg::NsymTwo;
		end else begin
			q_data.bits = {item.data_byte, 16'h0000};
			q_data.nsym = b64se_pkg::NsymOne;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (emit) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				if (cnt_q == 2'd0) begin
					pend_q <= {item.data_byte, 8'h00};
				end else begin
					pend_q <= {pend_q[15:8], item.data_byte};
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/b64se_gq.sv @@
// short queue of classified groups between front and back
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64se_gq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire b64se_pkg::grp_t wr_data,
	output logic                 full,
	input  wire logic            rd,
	output b64se_pkg::grp_t      rd_data,
	output logic                 empty
);

	localparam int Depth = b64se_pkg::GrpQDepth;
	localparam int PtrW  = b64se_pkg::GrpQPtrW;
	localparam int CntW  = b64se_pkg::GrpQCntW;

	b64se_pkg::grp_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/b64se_back.sv @@
// back end: serializes a group to four chars, one per cycle unless stalled
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64se_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire b64se_pkg::grp_t   q_data,
	output logic                   q_pop,
	output logic                   empty,
	input  wire logic              pop,
	output b64se_pkg::out_item_t   result
);

	b64se_pkg::grp_t      grp_q;
	logic                 busy_q;
	logic [1:0]           idx_q;
	b64se_pkg::out_item_t out_q;
	logic                 out_vld_q;
	logic                 emit;
	logic                 load;
	logic [5:0]           sel;
	logic [6:0]           ch;

	// a character moves out when the output register is free or being drained
	assign emit   = busy_q && (!out_vld_q || pop);
	assign load   = !busy_q || (emit && idx_q == 2'd3);
	assign q_pop  = load && !q_empty;
	assign empty  = !out_vld_q;
	assign result = out_q;

	always_comb begin
		unique case (idx_q)
			2'd0: sel = grp_q.bits[23:18];
			2'd1: sel = grp_q.bits[17:12];
			2'd2: sel = grp_q.bits[11:6];
			2'd3: sel = grp_q.bits[5:0];
			default: sel = '0;
		endcase
		ch = ({1'b0, idx_q} < grp_q.nsym) ? b64se_pkg::sym_char(sel) : b64se_pkg::PadChar;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_char  <= ch;
			out_q.last_char <= grp_q.fin && (idx_q == 2'd3);
		end
		if (q_pop) begin
			grp_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (load) begin
				busy_q <= !q_empty;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q  <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder_unit.sv @@
// top level of the base64 stream encoder: front, group queue, back
// depends on b64se_pkg, b64se_front, b64se_gq, b64se_back
//
// usage:
//   input channel: raw bytes in item (data_byte, last_byte); a request is
//   taken at a clock edge with push high and full low. last_byte marks the
//   final byte of a message.
//   result channel: characters in result (out_char, last_char); while empty
//   is low the oldest character is shown, and pop with empty low takes it.
//   last_char marks the final character of the encoded message.
// path: a byte that closes a group passes through the group queue and the
//   back's group register before its first character is shown; the other
//   three follow one per cycle while pop drains the output register.
// throughput: one character per cycle out of the serializer while pop
//   keeps draining; bytes that only fill the pending register are taken
//   every cycle while the group queue (two entries) has room.
// reset: arst_n low clears the pending bytes, the queue and the output
//   register; empty goes high and full low.
// stall: when pop stays low the output register holds, the serializer
//   stops, the group queue fills and full rises until room frees up.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire b64se_pkg::in_item_t  item,
	output logic                      empty,
	input  wire logic                 pop,
	output b64se_pkg::out_item_t      result
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	b64se_pkg::grp_t q_wr_data;
	b64se_pkg::grp_t q_rd_data;

	b64se_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_data (q_wr_data),
		.q_full (q_full)
	);

	b64se_gq u_gq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	b64se_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	// front never hands a group to a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group request while queue full");

	// back never takes a group from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("group taken from empty queue");

	// a group pushed into an empty queue is visible at the next edge
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_empty |=> !q_empty)
		else $error("pushed group lost");

	// marked final character is the fourth of a group, so pad or symbol only
	a_last_char_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.last_char |-> result.out_char >= 7'd43)
		else $error("final character out of range");
`endif

endmodule

`default_nettype wire

@@ sim/b64se_stream_checker.sv @@
// character checker for the base64 stream encoder: watches both queue sides,
// predicts the encoded characters of every accepted byte and compares them in order
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_stream_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic                 full,
	input  wire b64se_pkg::in_item_t  item,
	input  wire logic                 empty,
	input  wire logic                 pop,
	input  wire b64se_pkg::out_item_t result,
	output int                        mismatch_count,
	output int                        chars_waiting
);

	localparam logic [8*64-1:0] Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	b64se_pkg::out_item_t expected_chars[$];
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	int          chars_checked;

	initial begin
		mismatch_count = 0;
		chars_waiting = 0;
		chars_checked = 0;
	end

	function automatic logic [6:0] symbol_of(input logic [5:0] idx);
		logic [7:0] c;
		c = Alphabet[8*(63 - idx) +: 8];
		return c[6:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on character %0d: %s got %0d expected %0d at %0t",
			chars_checked, what, got, want, $time);
		mismatch_count++;
	endtask

	// a byte either waits in the held register or closes a group of four characters
	task automatic encode_byte(input b64se_pkg::in_item_t it);
		logic [23:0]          group;
		int                   nsym;
		b64se_pkg::out_item_t ch;
		if (held_count >= 2'd2) begin
			group = {held_bytes, it.data_byte};
			nsym = 4;
		end else if (!it.last_byte) begin
			if (held_count == 2'd0) begin
				held_bytes = {it.data_byte, 8'h00};
			end else begin
				held_bytes[7:0] = it.data_byte;
			end
			held_count = held_count + 2'd1;
			return;
		end else if (held_count == 2'd1) begin
			group = {held_bytes[15:8], it.data_byte, 8'h00};
			nsym = 3;
		end else begin
			group = {it.data_byte, 16'h0000};
			nsym = 2;
		end
		for (int k = 0; k < 4; k++) begin
			ch.out_char = (k < nsym) ? symbol_of(group[23 - 6*k -: 6]) : b64se_pkg::PadChar;
			ch.last_char = (k == 3) ? it.last_byte : 1'b0;
			expected_chars.push_back(ch);
		end
		held_bytes = 16'h0000;
		held_count = 2'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes = 16'h0000;
			held_count = 2'd0;
			expected_chars.delete();
			chars_waiting <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected character", result.out_char, -1);
				end else begin
					b64se_pkg::out_item_t want;
					want = expected_chars.pop_front();
					if (result.out_char !== want.out_char)
						report_mismatch("out_char", result.out_char, want.out_char);
					if (result.last_char !== want.last_char)
						report_mismatch("last_char", result.last_char, want.last_char);
				end
				chars_checked++;
			end
			if (push && !full) begin
				encode_byte(item);
			end
			chars_waiting <= expected_chars.size();
		end
	end

endmodule

@@ sim/tb_base64_stream_encoder_unit.sv @@
// testbench top for base64_stream_encoder_unit: feeds messages of raw bytes with
// random gaps and pop stalls, and gives the verdict from b64se_stream_checker
// depends on b64se_pkg, b64se_stream_checker and the encoder rtl
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;

	localparam int MessageBytes = 380;
	localparam int CycleLimit   = 200000;
	localparam int DrainCycles  = 20;
	localparam int LongHold     = 300;
	localparam int DirectedLen  = 19;

	// short messages: two lone final bytes, two bytes, full final group,
	// two full groups then one-byte tail, full group then two-byte tail, plus alphabet extremes
	localparam b64se_pkg::in_item_t DirectedBytes [DirectedLen] = '{
		{8'h00, 1'b1},
		{8'hFF, 1'b1},
		{8'h00, 1'b0}, {8'hFF, 1'b1},
		{8'hFF, 1'b0}, {8'h00, 1'b0}, {8'hFB, 1'b1},
		{8'hFB, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
		{8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h80, 1'b1},
		{8'h01, 1'b0}, {8'h02, 1'b0}, {8'h03, 1'b0}, {8'h04, 1'b0}, {8'h05, 1'b1}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 pop = 1'b0;
	b64se_pkg::in_item_t  item = '0;
	logic                 full;
	logic                 empty;
	b64se_pkg::out_item_t result;
	int                   mismatch_count;
	int                   chars_waiting;
	int                   cycle_count;
	bit                   tx_burst = 1'b0;

	base64_stream_encoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	b64se_stream_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.item           (item),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.mismatch_count (mismatch_count),
		.chars_waiting  (chars_waiting)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit no_idle);
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input b64se_pkg::in_item_t it);
		int gap;
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	initial begin
		int         sent;
		int         len;
		int         r;
		logic [7:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirectedLen; i++) begin
			send_byte(DirectedBytes[i]);
		end

		sent = DirectedLen;
		while (sent < MessageBytes) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 50) len = $urandom_range(1, 3);
			else if (r < 85) len = $urandom_range(4, 9);
			else len = $urandom_range(10, 24);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 9);
				if (r == 0) b = 8'h00;
				else if (r == 1) b = 8'hFF;
				else b = 8'($urandom);
				send_byte({b, (i == len - 1)});
				sent++;
			end
		end
		push <= 1'b0;

		// let the checker count the last request before waiting on it
		@(posedge clk);
		while (chars_waiting != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// pop side: random stalls, one long hold-off so the encoder backs up into full
	initial begin
		int rounds;
		int stall;
		int hold;
		bit rx_burst;
		rounds = 0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rounds % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
			stall = (rounds == 30) ? LongHold : pick_gap(rx_burst);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			hold = $urandom_range(1, 6);
			repeat (hold) @(posedge clk);
			rounds++;
		end
	end

endmodule

@@ filelist.f @@
rtl/b64se_pkg.sv
rtl/b64se_front.sv
rtl/b64se_gq.sv
rtl/b64se_back.sv
rtl/base64_stream_encoder_unit.sv
sim/b64se_stream_checker.sv
sim/tb_base64_stream_encoder_unit.sv
